// File: hdl/pixel_mask_collision_assert.svh
// assertion macros for the pixel mask collision block
`ifndef PIXEL_MASK_COLLISION_ASSERT_SVH
`define PIXEL_MASK_COLLISION_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked outside reset
`define PMC_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmc: same-cycle check failed");
// next-cycle implication, checked outside reset
`define PMC_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmc: next-cycle check failed");
`else
`define PMC_IMPLY(lbl, clk, rst_n, ante, cons)
`define PMC_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/pmc_pkg.sv
`default_nettype none

package pmc_pkg;

    // fixed field widths
    localparam int DIM_W = 7;
    localparam int PTR_W = 2 * DIM_W;

    // largest mask side; the widths above are sized for it
    localparam int MAX_DIM = 64;

    // opcodes
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_A_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_A_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_B_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_B_HEIGHT = 2'd3;

    localparam logic [DIM_W-1:0] CFG_DIM_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OVL1,
        ST_OVL2,
        ST_BASE,
        ST_INIT,
        ST_SCAN,
        ST_TAIL,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic capture;
        logic ovl1;
        logic ovl2;
        logic base;
        logic init;
        logic step;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic last;
        logic hit;
    } t_dp_sts;

    // clamp a size register to the largest mask dimension
    function automatic logic [DIM_W-1:0] dim_sat(input logic [DIM_W-1:0] raw,
                                                 input int max_dim);
        return (int'(raw) > max_dim) ? DIM_W'(max_dim) : raw;
    endfunction

endpackage

`default_nettype wire

// File: hdl/pmc_datapath.sv
`default_nettype none

module pmc_datapath #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [pmc_pkg::DIM_W-1:0]     i_cfg_data,
    input  wire logic [11:0]                   i_pixel_index,
    input  wire logic [7:0]                    i_pixel_value,
    input  wire logic signed [COORD_BITS-1:0]  i_a_left,
    input  wire logic signed [COORD_BITS-1:0]  i_a_top,
    input  wire logic signed [COORD_BITS-1:0]  i_b_left,
    input  wire logic signed [COORD_BITS-1:0]  i_b_top,
    input  wire pmc_pkg::t_dp_cmd              i_cmd,
    output pmc_pkg::t_dp_sts                   o_sts
);
    import pmc_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // size registers
    logic [DIM_W-1:0] r_a_width, r_a_height, r_b_width, r_b_height;
    logic [DIM_W-1:0] aw, ah, bw, bh;

    // captured corners and overlap bounds
    logic signed [CW-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [CW-1:0] r_x0, r_y0;
    logic signed [CW:0]   r_ax_end, r_ay_end, r_bx_end, r_by_end;
    logic signed [CW:0]   x1, y1, x0e, y0e;

    // overlap geometry in mask coordinates
    logic             r_empty;
    logic [DIM_W-1:0] r_ow, r_oh;
    logic [DIM_W-1:0] r_a_xoff, r_a_yoff, r_b_xoff, r_b_yoff;
    logic [PTR_W-1:0] r_prod_a, r_prod_b;

    // scan state
    logic [DIM_W-1:0] r_col, r_row;
    logic [PTR_W-1:0] r_row_a, r_row_b, r_ptr_a, r_ptr_b;
    logic             last_col, last_row;
    logic             r_rd_vld;
    logic             r_qa, r_qb;

    // mask stores
    logic             mem_a [DEPTH];
    logic             mem_b [DEPTH];
    logic             wr_ok;
    logic             solid;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_width  <= CFG_DIM_RESET;
            r_a_height <= CFG_DIM_RESET;
            r_b_width  <= CFG_DIM_RESET;
            r_b_height <= CFG_DIM_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_A_WIDTH:  r_a_width  <= i_cfg_data;
                CFG_A_HEIGHT: r_a_height <= i_cfg_data;
                CFG_B_WIDTH:  r_b_width  <= i_cfg_data;
                CFG_B_HEIGHT: r_b_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign aw = dim_sat(r_a_width, MAX_DIM);
    assign ah = dim_sat(r_a_height, MAX_DIM);
    assign bw = dim_sat(r_b_width, MAX_DIM);
    assign bh = dim_sat(r_b_height, MAX_DIM);

    // mask loads
    assign wr_ok = (32'(i_pixel_index) < DEPTH);
    assign solid = |i_pixel_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && wr_ok) begin
            mem_a[AW'(i_pixel_index)] <= solid;
        end
        if (i_cmd.step) begin
            r_qa <= mem_a[AW'(r_ptr_a)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_b && wr_ok) begin
            mem_b[AW'(i_pixel_index)] <= solid;
        end
        if (i_cmd.step) begin
            r_qb <= mem_b[AW'(r_ptr_b)];
        end
    end

    // capture corners, then far edges and near overlap corner
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ax <= i_a_left;
            r_ay <= i_a_top;
            r_bx <= i_b_left;
            r_by <= i_b_top;
        end
        if (i_cmd.ovl1) begin
            r_ax_end <= $signed({r_ax[CW-1], r_ax}) + $signed({{(CW+1-DIM_W){1'b0}}, aw});
            r_ay_end <= $signed({r_ay[CW-1], r_ay}) + $signed({{(CW+1-DIM_W){1'b0}}, ah});
            r_bx_end <= $signed({r_bx[CW-1], r_bx}) + $signed({{(CW+1-DIM_W){1'b0}}, bw});
            r_by_end <= $signed({r_by[CW-1], r_by}) + $signed({{(CW+1-DIM_W){1'b0}}, bh});
            r_x0     <= (r_ax > r_bx) ? r_ax : r_bx;
            r_y0     <= (r_ay > r_by) ? r_ay : r_by;
        end
    end

    // far overlap corner, emptiness, size and offsets, then the row base products
    assign x1  = (r_ax_end < r_bx_end) ? r_ax_end : r_bx_end;
    assign y1  = (r_ay_end < r_by_end) ? r_ay_end : r_by_end;
    assign x0e = $signed({r_x0[CW-1], r_x0});
    assign y0e = $signed({r_y0[CW-1], r_y0});

    always_ff @(posedge i_clk) begin
        if (i_cmd.ovl2) begin
            r_empty  <= (x0e >= x1) || (y0e >= y1);
            r_ow     <= DIM_W'(x1 - x0e);
            r_oh     <= DIM_W'(y1 - y0e);
            r_a_xoff <= DIM_W'(r_x0 - r_ax);
            r_a_yoff <= DIM_W'(r_y0 - r_ay);
            r_b_xoff <= DIM_W'(r_x0 - r_bx);
            r_b_yoff <= DIM_W'(r_y0 - r_by);
        end
        if (i_cmd.base) begin
            r_prod_a <= PTR_W'(aw) * PTR_W'(r_a_yoff);
            r_prod_b <= PTR_W'(bw) * PTR_W'(r_b_yoff);
        end
    end

    // overlap scan, one pixel a cycle from both stores
    assign last_col = (DIM_W'(r_col + DIM_W'(1)) == r_ow);
    assign last_row = (DIM_W'(r_row + DIM_W'(1)) == r_oh);

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_col   <= '0;
            r_row   <= '0;
            r_row_a <= r_prod_a + PTR_W'(r_a_xoff);
            r_ptr_a <= r_prod_a + PTR_W'(r_a_xoff);
            r_row_b <= r_prod_b + PTR_W'(r_b_xoff);
            r_ptr_b <= r_prod_b + PTR_W'(r_b_xoff);
        end else if (i_cmd.step) begin
            if (last_col) begin
                r_col   <= '0;
                r_row   <= DIM_W'(r_row + DIM_W'(1));
                r_row_a <= r_row_a + PTR_W'(aw);
                r_ptr_a <= r_row_a + PTR_W'(aw);
                r_row_b <= r_row_b + PTR_W'(bw);
                r_ptr_b <= r_row_b + PTR_W'(bw);
            end else begin
                r_col   <= DIM_W'(r_col + DIM_W'(1));
                r_ptr_a <= r_ptr_a + PTR_W'(1);
                r_ptr_b <= r_ptr_b + PTR_W'(1);
            end
        end
    end

    // read data valid in the cycle after the address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.step;
        end
    end

    // status
    assign o_sts.empty = r_empty;
    assign o_sts.last  = last_col && last_row;
    assign o_sts.hit   = r_rd_vld && r_qa && r_qb;

endmodule

`default_nettype wire

// File: hdl/pmc_ctrl.sv
`default_nettype none

`include "pixel_mask_collision_assert.svh"

module pmc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_opcode,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_collided,
    output pmc_pkg::t_dp_cmd       o_cmd,
    input  wire pmc_pkg::t_dp_sts  i_sts
);
    import pmc_pkg::*;

    t_state r_state, n_state;
    logic   r_res, n_res;
    logic   r_out_valid, r_out_collided;
    logic   out_free;
    logic   take;

    assign take     = (r_state == ST_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_res   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        case (r_state)
            ST_IDLE: begin
                if (take && (i_opcode == OP_CHECK)) begin
                    n_state = ST_OVL1;
                end
            end
            ST_OVL1: n_state = ST_OVL2;
            ST_OVL2: n_state = ST_BASE;
            ST_BASE: begin
                if (i_sts.empty) begin
                    n_state = ST_DONE;
                    n_res   = 1'b0;
                end else begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_sts.hit) begin
                    n_state = ST_DONE;
                    n_res   = 1'b1;
                end else if (i_sts.last) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                n_state = ST_DONE;
                n_res   = i_sts.hit;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_a  = take && (i_opcode == OP_LOAD_A);
                o_cmd.load_b  = take && (i_opcode == OP_LOAD_B);
                o_cmd.capture = take && (i_opcode == OP_CHECK);
            end
            ST_OVL1: o_cmd.ovl1 = 1'b1;
            ST_OVL2: o_cmd.ovl2 = 1'b1;
            ST_BASE: o_cmd.base = 1'b1;
            ST_INIT: o_cmd.init = 1'b1;
            ST_SCAN: o_cmd.step = !i_sts.hit;
            default: ;
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_out_collided <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_collided  = r_out_collided;

    // a check word starts the overlap setup
    `PMC_NEXT(a_check_starts, i_clk, i_rst_n, take && (i_opcode == OP_CHECK), r_state == ST_OVL1)
    // a hit is only seen while scanning
    `PMC_IMPLY(a_hit_in_scan, i_clk, i_rst_n, i_sts.hit, (r_state == ST_SCAN) || (r_state == ST_TAIL))
    // a collision result comes only from a hit
    `PMC_IMPLY(a_res_from_hit, i_clk, i_rst_n, (r_state == ST_DONE) && ($past(r_state) != ST_DONE) && r_res, $past(i_sts.hit))
    // an output word is only loaded from the done state
    `PMC_IMPLY(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == ST_DONE)

endmodule

`default_nettype wire

// File: hdl/pixel_mask_collision.sv
// load words are accepted back to back while idle
// a check steps through the setup states OVL1, OVL2, BASE and INIT, scans one
// overlap pixel per cycle (stopping at the first hit), waits for the last read
// and loads the output register; an empty overlap goes from BASE to DONE
// the next word waits for that load; a stalled full output holds the check
// synchronous active-low reset clears control and size registers; no clearing pass
`default_nettype none

module pixel_mask_collision #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic [11:0]                   i_pixel_index,
    input  wire logic [7:0]                    i_pixel_value,
    input  wire logic signed [COORD_BITS-1:0]  i_a_left,
    input  wire logic signed [COORD_BITS-1:0]  i_a_top,
    input  wire logic signed [COORD_BITS-1:0]  i_b_left,
    input  wire logic signed [COORD_BITS-1:0]  i_b_top,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_collided,
    // configuration channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [pmc_pkg::DIM_W-1:0]     i_cfg_data
);
    import pmc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // size registers take a write every cycle
    assign o_cfg_ready = 1'b1;

    pmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_collided  (o_collided),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    pmc_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pixel_index (i_pixel_index),
        .i_pixel_value (i_pixel_value),
        .i_a_left      (i_a_left),
        .i_a_top       (i_a_top),
        .i_b_left      (i_b_left),
        .i_b_top       (i_b_top),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

`default_nettype wire

// File: dv/tb_pixel_mask_collision.sv
`default_nettype none

module tb_pixel_mask_collision;
    import pmc_pkg::*;

    localparam int COORD_BITS    = 16;
    localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 40;
    localparam int ITEM_TARGET   = 900;
    localparam int MAX_WAIT      = 13;
    localparam int FILL_CAP      = 128;
    localparam int REFRESH_SPAN  = 64;
    localparam int PAD           = 2 * MAX_DIM + 2;

    // opcode the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [DIM_W-1:0] t_dim_reg;

    typedef struct {
        logic [1:0]  op;
        logic [11:0] index;
        logic [7:0]  value;
        t_coord      a_left;
        t_coord      a_top;
        t_coord      b_left;
        t_coord      b_top;
    } t_pixel_word;

    // mask and size shadow plus the queue of pending collision flags
    class collision_scoreboard;
        t_dim_reg size_reg[4];
        bit       solid_a[STORE_DEPTH];
        bit       solid_b[STORE_DEPTH];
        bit       loaded_a[STORE_DEPTH];
        bit       loaded_b[STORE_DEPTH];
        bit       expected_hits[$];
        int       errors;

        function new();
            foreach (size_reg[i]) size_reg[i] = CFG_DIM_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, t_dim_reg val);
            size_reg[idx] = val;
        endfunction

        // size register clamped to the largest mask dimension
        function int span(logic [1:0] idx);
            return (int'(size_reg[idx]) > MAX_DIM) ? MAX_DIM : int'(size_reg[idx]);
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction

        // walk the overlap rectangle row by row in each mask's own coordinates
        // legality mode: 1 if every covered pixel was loaded in both masks
        // otherwise: 1 at the first pixel solid in both masks
        function bit walk_overlap(t_pixel_word w, bit legality);
            int ax, ay, bx, by, aw, ah, bw, bh;
            int x0, y0, x1, y1, ia, ib;
            ax = w.a_left;
            ay = w.a_top;
            bx = w.b_left;
            by = w.b_top;
            aw = span(CFG_A_WIDTH);
            ah = span(CFG_A_HEIGHT);
            bw = span(CFG_B_WIDTH);
            bh = span(CFG_B_HEIGHT);
            x0 = (ax > bx) ? ax : bx;
            y0 = (ay > by) ? ay : by;
            x1 = (ax + aw < bx + bw) ? ax + aw : bx + bw;
            y1 = (ay + ah < by + bh) ? ay + ah : by + bh;
            for (int y = y0; y < y1; y++) begin
                for (int x = x0; x < x1; x++) begin
                    ia = aw * (y - ay) + (x - ax);
                    ib = bw * (y - by) + (x - bx);
                    if (legality) begin
                        if (!loaded_a[ia] || !loaded_b[ib]) return 1'b0;
                    end else if (solid_a[ia] && solid_b[ib]) begin
                        return 1'b1;
                    end
                end
            end
            return legality;
        endfunction

        // accepted input word
        function void note_word(t_pixel_word w);
            bit solid;
            solid = (w.value != 8'd0);
            case (w.op)
                OP_LOAD_A: begin
                    solid_a[w.index]  = solid;
                    loaded_a[w.index] = 1'b1;
                end
                OP_LOAD_B: begin
                    solid_b[w.index]  = solid;
                    loaded_b[w.index] = 1'b1;
                end
                OP_CHECK: begin
                    expected_hits.push_back(walk_overlap(w, 1'b0));
                end
                default: begin
                end
            endcase
        endfunction

        // accepted result word against the oldest pending flag
        function void check_result(logic collided);
            bit want;
            if (expected_hits.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result collided=%0b, no check pending", collided);
            end else begin
                want = expected_hits.pop_front();
                if (collided !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("collided mismatch: expected %0b actual %0b", want, collided);
                end
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    logic [1:0]  opcode;
    logic [11:0] pixel_index;
    logic [7:0]  pixel_value;
    t_coord   a_left, a_top, b_left, b_top;
    logic     out_valid;
    logic     out_stall;
    logic     collided;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [1:0] cfg_index;
    t_dim_reg cfg_data;

    collision_scoreboard hits_board;
    bit  in_quiet  = 1'b0;
    bit  out_quiet = 1'b0;
    int  words_sent = 0;
    int  cycles = 0;

    pixel_mask_collision dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_pixel_index (pixel_index),
        .i_pixel_value (pixel_value),
        .i_a_left      (a_left),
        .i_a_top       (a_top),
        .i_b_left      (b_left),
        .i_b_top       (b_top),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_collided    (collided),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    // run guard
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // idle length per word, with occasional stretches of no idling
    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 31) == 0) quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic t_pixel_word random_word();
        t_pixel_word w;
        w.op     = OP_UNUSED;
        w.index  = 12'($urandom_range(0, STORE_DEPTH - 1));
        w.value  = 8'($urandom);
        w.a_left = t_coord'($urandom);
        w.a_top  = t_coord'($urandom);
        w.b_left = t_coord'($urandom);
        w.b_top  = t_coord'($urandom);
        return w;
    endfunction

    function automatic t_pixel_word load_word(logic [1:0] op, int idx, logic [7:0] val);
        t_pixel_word w;
        w       = random_word();
        w.op    = op;
        w.index = 12'(idx);
        w.value = val;
        return w;
    endfunction

    function automatic t_pixel_word check_word(int al, int at, int bl, int bt);
        t_pixel_word w;
        w        = random_word();
        w.op     = OP_CHECK;
        w.a_left = t_coord'(al);
        w.a_top  = t_coord'(at);
        w.b_left = t_coord'(bl);
        w.b_top  = t_coord'(bt);
        return w;
    endfunction

    // a check that would touch a never-loaded entry moves sprite b half the
    // coordinate range away, which can never overlap
    function automatic t_pixel_word legalize(t_pixel_word w);
        if (!hits_board.walk_overlap(w, 1'b1)) w.b_left = w.b_left ^ 16'h8000;
        return w;
    endfunction

    // sprite b placed from just touching on one side to just touching on the other
    function automatic t_pixel_word placed_check();
        t_pixel_word w;
        int aw, ah, bw, bh, ax, ay;
        aw = hits_board.span(CFG_A_WIDTH);
        ah = hits_board.span(CFG_A_HEIGHT);
        bw = hits_board.span(CFG_B_WIDTH);
        bh = hits_board.span(CFG_B_HEIGHT);
        for (int t = 0; t < 8; t++) begin
            ax = int'($urandom_range(0, 65535 - 2 * PAD)) - 32768 + PAD;
            ay = int'($urandom_range(0, 65535 - 2 * PAD)) - 32768 + PAD;
            w = check_word(ax, ay, ax + int'($urandom_range(0, aw + bw)) - bw,
                           ay + int'($urandom_range(0, ah + bh)) - bh);
            if (hits_board.walk_overlap(w, 1'b1)) break;
        end
        return legalize(w);
    endfunction

    function automatic logic [7:0] pixel_byte(int density);
        return (int'($urandom_range(0, 99)) < density) ? 8'($urandom_range(1, 255)) : 8'd0;
    endfunction

    function automatic int mask_density();
        return $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 100);
    endfunction

    function automatic t_dim_reg random_size();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return $urandom_range(0, 1) ? 7'd127 : 7'($urandom_range(64, 127));
        if (pick < 4) return 7'($urandom_range(9, 64));
        return 7'($urandom_range(1, 8));
    endfunction

    // one input word: optional idle gap, then hold until taken
    task automatic send_word(t_pixel_word w);
        int gap;
        gap = draw_wait(in_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= w.op;
        pixel_index <= w.index;
        pixel_value <= w.value;
        a_left      <= w.a_left;
        a_top       <= w.a_top;
        b_left      <= w.b_left;
        b_top       <= w.b_top;
        do @(posedge clk); while (in_stall);
        hits_board.note_word(w);
        if (w.op != OP_UNUSED) words_sent++;
    endtask

    // let every pending result come back and the block go quiet
    task automatic drain(int settle);
        in_valid <= 1'b0;
        while (hits_board.pending() > 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // all four size registers, valid held high across the writes
    task automatic write_sizes(t_dim_reg aw, t_dim_reg ah, t_dim_reg bw, t_dim_reg bh);
        logic [1:0] reg_idx[4];
        t_dim_reg   vals[4];
        reg_idx = '{CFG_A_WIDTH, CFG_A_HEIGHT, CFG_B_WIDTH, CFG_B_HEIGHT};
        vals    = '{aw, ah, bw, bh};
        cfg_valid <= 1'b1;
        for (int r = 0; r < 4; r++) begin
            cfg_index <= reg_idx[r];
            cfg_data  <= vals[r];
            do @(posedge clk); while (!cfg_ready);
            hits_board.set_reg(reg_idx[r], vals[r]);
        end
        cfg_valid <= 1'b0;
    endtask

    // row-major mask fill: the head is always refreshed, the rest only if never loaded
    task automatic load_mask(logic [1:0] op, int area, int density);
        bit seen;
        for (int idx = 0; idx < area && idx < FILL_CAP; idx++) begin
            seen = (op == OP_LOAD_A) ? hits_board.loaded_a[idx] : hits_board.loaded_b[idx];
            if (idx < REFRESH_SPAN || !seen) send_word(load_word(op, idx, pixel_byte(density)));
        end
    endtask

    // new sizes, fresh masks, then a mix of checks, reloads and noise
    task automatic run_phase(t_dim_reg aw, t_dim_reg ah, t_dim_reg bw, t_dim_reg bh,
                             int body_words);
        int density_a, density_b, area_a, area_b, pick, area;
        logic [1:0] op;
        drain(SETTLE_CYCLES);
        write_sizes(aw, ah, bw, bh);
        density_a = mask_density();
        density_b = mask_density();
        area_a = hits_board.span(CFG_A_WIDTH) * hits_board.span(CFG_A_HEIGHT);
        area_b = hits_board.span(CFG_B_WIDTH) * hits_board.span(CFG_B_HEIGHT);
        load_mask(OP_LOAD_A, area_a, density_a);
        load_mask(OP_LOAD_B, area_b, density_b);
        repeat (body_words) begin
            pick = $urandom_range(0, 99);
            op   = $urandom_range(0, 1) ? OP_LOAD_A : OP_LOAD_B;
            area = (op == OP_LOAD_A) ? area_a : area_b;
            if (area > FILL_CAP) area = FILL_CAP;
            if (pick < 60) begin
                send_word(placed_check());
            end else if (pick < 75 && area > 0) begin
                send_word(load_word(op, $urandom_range(0, area - 1),
                                    pixel_byte(op == OP_LOAD_A ? density_a : density_b)));
            end else if (pick < 85) begin
                send_word(load_word(op, $urandom_range(0, STORE_DEPTH - 1), 8'($urandom)));
            end else if (pick < 93) begin
                send_word(legalize(check_word($urandom, $urandom, $urandom, $urandom)));
            end else begin
                send_word(random_word());
            end
        end
    endtask

    // result side: random stall, then take one word and compare it
    initial begin : collect_results
        int hold;
        out_stall <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            hold = draw_wait(out_quiet);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            hits_board.check_result(collided);
        end
    end

    initial begin : stimulus
        hits_board   = new();
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        opcode      <= OP_LOAD_A;
        pixel_index <= '0;
        pixel_value <= '0;
        a_left      <= '0;
        a_top       <= '0;
        b_left      <= '0;
        b_top       <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_A_WIDTH;
        cfg_data    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset sizes: index extremes, far apart, touching edges, ignored opcode
        send_word(load_word(OP_LOAD_A, STORE_DEPTH - 1, 8'hFF));
        send_word(load_word(OP_LOAD_B, 0, 8'h00));
        send_word(check_word(-32768, -32768, 32767, 32767));
        send_word(check_word(0, 0, 64, 0));
        send_word(check_word(0, 0, 0, -64));
        send_word(random_word());

        // 2x2 masks: a fully solid, b solid only at its bottom-right pixel
        drain(SETTLE_CYCLES);
        write_sizes(7'd2, 7'd2, 7'd2, 7'd2);
        send_word(load_word(OP_LOAD_A, 0, 8'hFF));
        send_word(load_word(OP_LOAD_A, 1, 8'h01));
        send_word(load_word(OP_LOAD_A, 2, 8'h80));
        send_word(load_word(OP_LOAD_A, 3, 8'h7F));
        send_word(load_word(OP_LOAD_B, 0, 8'h00));
        send_word(load_word(OP_LOAD_B, 1, 8'h00));
        send_word(load_word(OP_LOAD_B, 2, 8'h00));
        send_word(load_word(OP_LOAD_B, 3, 8'h80));
        send_word(check_word(0, 0, 0, 0));
        send_word(check_word(0, 0, 1, 1));
        send_word(check_word(1, 1, 0, 0));
        send_word(check_word(0, 0, 2, 0));
        send_word(check_word(-32768, -32768, -32768, -32768));
        send_word(check_word(32767, 32767, 32766, 32766));

        // empty sprites never collide
        drain(SETTLE_CYCLES);
        write_sizes(7'd0, 7'd2, 7'd2, 7'd2);
        send_word(check_word(0, 0, 0, 0));
        drain(SETTLE_CYCLES);
        write_sizes(7'd2, 7'd2, 7'd2, 7'd0);
        send_word(check_word(0, 0, 0, 0));

        // fixed size corners, saturation among them
        run_phase(7'd1, 7'd1, 7'd1, 7'd1, 20);
        run_phase(7'd127, 7'd1, 7'd1, 7'd127, 30);
        run_phase(7'd64, 7'd3, 7'd5, 7'd127, 30);
        run_phase(7'd127, 7'd127, 7'd4, 7'd4, 40);

        // random sizes until the word budget is spent
        while (words_sent < ITEM_TARGET)
            run_phase(random_size(), random_size(), random_size(), random_size(),
                      $urandom_range(20, 50));

        drain(TAIL_CYCLES);
        if (hits_board.errors == 0 && hits_board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: pixel_mask_collision.f
+incdir+hdl
hdl/pmc_pkg.sv
hdl/pmc_datapath.sv
hdl/pmc_ctrl.sv
hdl/pixel_mask_collision.sv
dv/tb_pixel_mask_collision.sv
